FILE: src/edfs_pkg.sv
// Shared types, operation codes and a helper function for the EDF scheduler.
`default_nettype none

package edfs_pkg;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [15:0] CLOCK_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic        tick;
        logic        hard;
        logic [15:0] clock;
        logic [7:0]  ld_ident;
        logic [15:0] ld_arrival;
        logic [15:0] ld_burst;
        logic [15:0] ld_deadline;
    } bcast_t;

    // Scan token handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic        valid;
        logic        have;
        logic [15:0] deadline;
        logic [15:0] arrival;
        logic [7:0]  ident;
        logic        started;
        logic        rem_one;
        logic [4:0]  drop_cnt;
        logic [1:0]  pend;
    } token_t;

    // A task that cannot finish between arrival and deadline
    function automatic logic load_infeasible(
        input logic [15:0] arrival,
        input logic [15:0] burst,
        input logic [15:0] deadline
    );
        logic [16:0] finish;
        finish = {1'b0, arrival} + {1'b0, burst};
        return (burst != 16'd0) && ({1'b0, deadline} < finish);
    endfunction

endpackage

`default_nettype wire

FILE: src/edfs_cell.sv
// One task slot of the scheduler chain: holds the slot and folds it into the scan token.
`default_nettype none

module edfs_cell
    import edfs_pkg::*;
#(
    parameter int SLOT_W   = 4,
    parameter int CELL_IDX = 0
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bcast_t            bc,
    input  wire logic              loaded,
    input  wire logic              wr_en,
    input  wire logic              dec_en,
    input  wire token_t            tok_in,
    input  wire logic [SLOT_W-1:0] pick_in,
    output token_t                 tok_out,
    output logic [SLOT_W-1:0]      pick_out
);

    logic [15:0] arrival_reg;
    logic [15:0] remaining_reg;
    logic [15:0] deadline_reg;
    logic [7:0]  ident_reg;
    logic        dropped_reg;
    logic        started_reg;

    token_t            tok_reg;
    token_t            tok_next;
    logic              tok_valid_reg;
    logic [SLOT_W-1:0] pick_reg;
    logic [SLOT_W-1:0] pick_next;

    logic        has_work;
    logic [16:0] finish_now;
    logic        drop_now;
    logic        live;
    logic        eligible;
    logic        beats;
    logic        take;

    always_comb
    begin
        has_work   = remaining_reg != 16'd0;
        finish_now = {1'b0, bc.clock} + {1'b0, remaining_reg};
        drop_now   = tok_in.valid && bc.tick && bc.hard && loaded && !dropped_reg
                     && has_work && (finish_now > {1'b0, deadline_reg});
        live       = loaded && !(dropped_reg || drop_now) && has_work;
        eligible   = bc.tick && live && (arrival_reg <= bc.clock);

        // Least deadline; hard mode breaks ties by arrival, then id
        if (deadline_reg != tok_in.deadline)
            beats = deadline_reg < tok_in.deadline;
        else if (!bc.hard)
            beats = 1'b0;
        else if (arrival_reg != tok_in.arrival)
            beats = arrival_reg < tok_in.arrival;
        else
            beats = ident_reg < tok_in.ident;

        take = eligible && (!tok_in.have || beats);

        tok_next          = tok_in;
        pick_next         = pick_in;
        tok_next.drop_cnt = tok_in.drop_cnt + {4'd0, drop_now};
        if (live && tok_in.pend != 2'd2)
            tok_next.pend = tok_in.pend + 2'd1;
        if (take)
        begin
            tok_next.have     = 1'b1;
            tok_next.deadline = deadline_reg;
            tok_next.arrival  = arrival_reg;
            tok_next.ident    = ident_reg;
            tok_next.started  = started_reg;
            tok_next.rem_one  = remaining_reg == 16'd1;
            pick_next         = SLOT_W'(CELL_IDX);
        end
    end

    // Slot contents
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            arrival_reg   <= bc.ld_arrival;
            remaining_reg <= bc.ld_burst;
            deadline_reg  <= bc.ld_deadline;
            ident_reg     <= bc.ld_ident;
            started_reg   <= 1'b0;
            dropped_reg   <= bc.hard &&
                             load_infeasible(bc.ld_arrival, bc.ld_burst, bc.ld_deadline);
        end
        else if (dec_en)
        begin
            remaining_reg <= remaining_reg - 16'd1;
            started_reg   <= 1'b1;
        end
        else if (drop_now)
        begin
            dropped_reg <= 1'b1;
        end
    end

    // Token stage toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_in.valid;
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        pick_reg <= pick_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
        pick_out      = pick_reg;
    end

endmodule

`default_nettype wire

FILE: src/edf_task_scheduler_unit.sv
// Top level of the EDF task scheduler: controller, task table chain and result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  in      | to block  | in_valid / in_stall   | func, task_id, arrival_time, burst_length,
//          |           |                       | deadline_time
//  out     | from block| out_valid / out_stall | ran_valid, ran_slot, ran_task, tick_time,
//          |           |                       | first_run, completed, newly_dropped,
//          |           |                       | work_pending, table_full
//  cfg     | to block  | cfg_valid / cfg_ready | cfg_hard_mode
//
//  Every item goes from acceptance to its result in steps: the scan token walks the cell
//  chain through the token register of each slot, the chain tail is latched, and the pick
//  is committed. The input reopens the cycle after the commit, so the block takes no new
//  item before the last one has committed.
//  Reset clears the fill count, the clock, the mode and all handshake state; slot contents
//  are written by loads and need no reset.
//  in_stall stays high while an item is in flight; a result waiting under out_stall holds
//  the commit, and the next item is taken as soon as the previous one has committed.
`default_nettype none

module edf_task_scheduler_unit
    import edfs_pkg::*;
#(
    parameter int MAX_TASKS = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  task_id,
    input  wire logic [15:0] arrival_time,
    input  wire logic [15:0] burst_length,
    input  wire logic [15:0] deadline_time,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ran_valid,
    output logic [3:0]       ran_slot,
    output logic [7:0]       ran_task,
    output logic [15:0]      tick_time,
    output logic             first_run,
    output logic             completed,
    output logic [4:0]       newly_dropped,
    output logic             work_pending,
    output logic             table_full,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_hard_mode
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    // Control state
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [15:0]       clock_reg;
    logic              hard_reg;
    logic              start_reg;
    logic              out_valid_reg;

    // Item bookkeeping
    logic              tick_reg;
    logic              full_reg;
    logic              ldrop_reg;
    token_t            res_reg;
    logic [SLOT_W-1:0] res_pick_reg;

    // Result register
    logic              ran_valid_reg;
    logic [3:0]        ran_slot_reg;
    logic [7:0]        ran_task_reg;
    logic [15:0]       tick_time_reg;
    logic              first_run_reg;
    logic              completed_reg;
    logic [4:0]        dropped_reg;
    logic              pending_reg;
    logic              table_full_reg;

    // Handshake and sequencing strobes
    logic              in_accept;
    logic              tbl_full;
    logic              do_load;
    logic              tail_seen;
    logic              out_free;
    logic              commit;

    bcast_t            bc;
    token_t            tok  [MAX_TASKS+1];
    logic [SLOT_W-1:0] pick [MAX_TASKS+1];
    logic [MAX_TASKS-1:0] loaded;
    logic [MAX_TASKS-1:0] wr_en;
    logic [MAX_TASKS-1:0] dec_en;

    logic              ran_now;
    logic              pend_after;
    logic [SLOT_W+3:0] slot_ext;

    assign in_accept = in_valid && !in_stall;
    assign tbl_full  = count_reg == CNT_W'(MAX_TASKS);
    assign do_load   = in_accept && (func == FUNC_LOAD) && !tbl_full;
    assign tail_seen = tok[MAX_TASKS].valid;
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == ST_DONE) && out_free;
    assign cfg_ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_accept) state_next = ST_SCAN;
            ST_SCAN: if (tail_seen) state_next = ST_DONE;
            ST_DONE: if (out_free)  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_SCAN: in_stall = 1'b1;
            ST_DONE: in_stall = 1'b1;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            clock_reg     <= 16'd0;
            hard_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_accept;
            if (cfg_valid && cfg_ready)
                hard_reg <= cfg_hard_mode;

            // Clear drops the table and zeroes the clock; load claims the next slot
            if (in_accept && func == FUNC_CLEAR)
            begin
                count_reg <= '0;
                clock_reg <= 16'd0;
            end
            else if (do_load)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (commit && tick_reg && clock_reg != CLOCK_MAX)
            begin
                clock_reg <= clock_reg + 16'd1;
            end

            if (commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the item kind at accept, and the scan result at the chain tail
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tick_reg  <= func == FUNC_TICK;
            full_reg  <= (func == FUNC_LOAD) && tbl_full;
            ldrop_reg <= do_load && hard_reg &&
                         load_infeasible(arrival_time, burst_length, deadline_time);
        end
        if (state_reg == ST_SCAN && tail_seen)
        begin
            res_reg      <= tok[MAX_TASKS];
            res_pick_reg <= pick[MAX_TASKS];
        end
    end

    // Broadcast to the cells and the head of the scan chain
    always_comb
    begin
        bc.tick        = tick_reg;
        bc.hard        = hard_reg;
        bc.clock       = clock_reg;
        bc.ld_ident    = task_id;
        bc.ld_arrival  = arrival_time;
        bc.ld_burst    = burst_length;
        bc.ld_deadline = deadline_time;

        tok[0]          = '0;
        tok[0].valid    = start_reg;
        pick[0]         = '0;
    end

    assign ran_now = tick_reg && res_reg.have;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            assign loaded[gi] = CNT_W'(gi) < count_reg;
            assign wr_en[gi]  = do_load && (count_reg == CNT_W'(gi));
            assign dec_en[gi] = commit && ran_now && (res_pick_reg == SLOT_W'(gi));

            edfs_cell #(
                .SLOT_W   (SLOT_W),
                .CELL_IDX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .bc       (bc),
                .loaded   (loaded[gi]),
                .wr_en    (wr_en[gi]),
                .dec_en   (dec_en[gi]),
                .tok_in   (tok[gi]),
                .pick_in  (pick[gi]),
                .tok_out  (tok[gi+1]),
                .pick_out (pick[gi+1])
            );
        end
    endgenerate

    // Work left after this item: the pick drops out only if it just finished
    always_comb
    begin
        pend_after = (res_reg.pend == 2'd2) ||
                     (res_reg.pend == 2'd1 && !(ran_now && res_reg.rem_one));
        slot_ext   = {4'd0, res_pick_reg};
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            ran_valid_reg  <= ran_now;
            ran_slot_reg   <= ran_now ? slot_ext[3:0] : 4'd0;
            ran_task_reg   <= ran_now ? res_reg.ident : 8'd0;
            tick_time_reg  <= clock_reg;
            first_run_reg  <= ran_now && !res_reg.started;
            completed_reg  <= ran_now && res_reg.rem_one;
            dropped_reg    <= res_reg.drop_cnt | {4'd0, ldrop_reg};
            pending_reg    <= pend_after;
            table_full_reg <= full_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ran_valid     = ran_valid_reg;
    assign ran_slot      = ran_slot_reg;
    assign ran_task      = ran_task_reg;
    assign tick_time     = tick_time_reg;
    assign first_run     = first_run_reg;
    assign completed     = completed_reg;
    assign newly_dropped = dropped_reg;
    assign work_pending  = pending_reg;
    assign table_full    = table_full_reg;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the EDF task scheduler unit with a shadow scheduler model.

module testbench;
    import edfs_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_MAX   = 60;

    // One input item as offered on the in channel
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  task_id;
        logic [15:0] arrival_time;
        logic [15:0] burst_length;
        logic [15:0] deadline_time;
    } sched_item_t;

    // One result item; field order matches the concatenation of the out ports
    typedef struct packed {
        logic        ran_valid;
        logic [3:0]  ran_slot;
        logic [7:0]  ran_task;
        logic [15:0] tick_time;
        logic        first_run;
        logic        completed;
        logic [4:0]  newly_dropped;
        logic        work_pending;
        logic        table_full;
    } sched_result_t;

    // Shadow copy of the task table; predicts each result and checks what comes out
    class schedule_tracker;
        bit            hard;
        bit [15:0]     slot_arr  [SLOTS];
        bit [15:0]     slot_rem  [SLOTS];
        bit [15:0]     slot_dl   [SLOTS];
        bit [7:0]      slot_id   [SLOTS];
        bit            slot_drop [SLOTS];
        bit            slot_run  [SLOTS];
        int            fill;
        bit [15:0]     now;
        sched_result_t expected_results [$];
        int            errors;

        function bit has_work();
            int i;
            for (i = 0; i < fill; i++)
                if (!slot_drop[i] && slot_rem[i] != 16'd0)
                    return 1'b1;
            return 1'b0;
        endfunction

        // Earlier deadline wins; hard mode then prefers earlier arrival, then lower id
        function bit outranks(int a, int b);
            if (slot_dl[a] != slot_dl[b])
                return slot_dl[a] < slot_dl[b];
            if (!hard)
                return 1'b0;
            if (slot_arr[a] != slot_arr[b])
                return slot_arr[a] < slot_arr[b];
            return slot_id[a] < slot_id[b];
        endfunction

        function void note_item(sched_item_t it);
            sched_result_t r;
            bit            have;
            int            pick;
            int            i;
            bit [16:0]     need;
            r = '0;
            have = 1'b0;
            pick = 0;
            r.tick_time = now;
            case (it.func)
                FUNC_CLEAR:
                begin
                    fill = 0;
                    now = '0;
                    r.tick_time = '0;
                end
                FUNC_LOAD:
                begin
                    if (fill >= SLOTS)
                        r.table_full = 1'b1;
                    else
                    begin
                        slot_arr[fill]  = it.arrival_time;
                        slot_rem[fill]  = it.burst_length;
                        slot_dl[fill]   = it.deadline_time;
                        slot_id[fill]   = it.task_id;
                        slot_run[fill]  = 1'b0;
                        slot_drop[fill] = 1'b0;
                        need = {1'b0, it.arrival_time} + {1'b0, it.burst_length};
                        if (hard && it.burst_length != 16'd0 && {1'b0, it.deadline_time} < need)
                        begin
                            slot_drop[fill] = 1'b1;
                            r.newly_dropped = 5'd1;
                        end
                        fill++;
                    end
                end
                FUNC_TICK:
                begin
                    for (i = 0; i < fill; i++)
                    begin
                        need = {1'b0, now} + {1'b0, slot_rem[i]};
                        if (hard && !slot_drop[i] && slot_rem[i] != 16'd0 &&
                            need > {1'b0, slot_dl[i]})
                        begin
                            slot_drop[i] = 1'b1;
                            r.newly_dropped = r.newly_dropped + 5'd1;
                        end
                        if (!slot_drop[i] && slot_rem[i] != 16'd0 && slot_arr[i] <= now &&
                            (!have || outranks(i, pick)))
                        begin
                            pick = i;
                            have = 1'b1;
                        end
                    end
                    if (have)
                    begin
                        r.ran_valid = 1'b1;
                        r.ran_slot  = pick[3:0];
                        r.ran_task  = slot_id[pick];
                        r.first_run = !slot_run[pick];
                        slot_run[pick] = 1'b1;
                        slot_rem[pick] = slot_rem[pick] - 16'd1;
                        r.completed = (slot_rem[pick] == 16'd0);
                    end
                    if (now != CLOCK_MAX)
                        now = now + 16'd1;
                end
                default: ;
            endcase
            r.work_pending = has_work();
            expected_results.push_back(r);
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                if (errors < REPORT_MAX)
                    $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (expected_results.size() == 0)
            begin
                if (errors < REPORT_MAX)
                    $display("%0t: result expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare("ran_valid",     16'(want.ran_valid),     16'(got.ran_valid));
            compare("ran_slot",      16'(want.ran_slot),      16'(got.ran_slot));
            compare("ran_task",      16'(want.ran_task),      16'(got.ran_task));
            compare("tick_time",     want.tick_time,          got.tick_time);
            compare("first_run",     16'(want.first_run),     16'(got.first_run));
            compare("completed",     16'(want.completed),     16'(got.completed));
            compare("newly_dropped", 16'(want.newly_dropped), 16'(got.newly_dropped));
            compare("work_pending",  16'(want.work_pending),  16'(got.work_pending));
            compare("table_full",    16'(want.table_full),    16'(got.table_full));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [7:0]  task_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [15:0] deadline_time;
    logic        out_valid;
    logic        out_stall;
    logic        ran_valid;
    logic [3:0]  ran_slot;
    logic [7:0]  ran_task;
    logic [15:0] tick_time;
    logic        first_run;
    logic        completed;
    logic [4:0]  newly_dropped;
    logic        work_pending;
    logic        table_full;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_hard_mode;

    schedule_tracker tracker;
    int              items_sent  = 0;
    int              cycle_count = 0;

    edf_task_scheduler_unit #(
        .MAX_TASKS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .task_id(task_id),
        .arrival_time(arrival_time),
        .burst_length(burst_length),
        .deadline_time(deadline_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ran_valid(ran_valid),
        .ran_slot(ran_slot),
        .ran_task(ran_task),
        .tick_time(tick_time),
        .first_run(first_run),
        .completed(completed),
        .newly_dropped(newly_dropped),
        .work_pending(work_pending),
        .table_full(table_full),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_hard_mode(cfg_hard_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Abort a hung run; the limit is many times the slowest legal run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("edf_task_scheduler_unit: mismatch");
        $finish;
    end

    // Offer one item and hold it until the block takes it. An optional idle gap
    // comes first; skip gaps inside the quiet window so back-to-back items are seen.
    task automatic push_item(input sched_item_t it);
        bit quiet;
        quiet = (items_sent >= 150 && items_sent < 260);
        if (!quiet && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= it.func;
        task_id       <= it.task_id;
        arrival_time  <= it.arrival_time;
        burst_length  <= it.burst_length;
        deadline_time <= it.deadline_time;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_item(it);
        items_sent++;
    endtask

    task automatic send(input logic [1:0] f, input logic [7:0] id, input logic [15:0] arr,
                        input logic [15:0] burst, input logic [15:0] dl);
        push_item('{func: f, task_id: id, arrival_time: arr, burst_length: burst,
                    deadline_time: dl});
    endtask

    // Change the mode only with nothing in flight: drop valid, drain, then write
    task automatic set_hard_mode(input bit hard);
        in_valid <= 1'b0;
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid     <= 1'b1;
        cfg_hard_mode <= hard;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.hard = hard;
    endtask

    // Mostly small, near-feasible tasks so that ties, drops and completions occur;
    // now and then a load with full-range fields.
    function automatic sched_item_t random_load();
        sched_item_t it;
        int          d;
        it.func = FUNC_LOAD;
        it.task_id = ($urandom_range(1) != 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        if ($urandom_range(9) == 0)
        begin
            it.arrival_time  = 16'($urandom_range(65535));
            it.burst_length  = 16'($urandom_range(65535));
            it.deadline_time = 16'($urandom_range(65535));
        end
        else
        begin
            it.arrival_time = 16'($urandom_range(12));
            it.burst_length = 16'($urandom_range(6));
            d = $urandom_range(14);
            d = int'(it.arrival_time) + int'(it.burst_length) + d - 3;
            if (d < 0)
                d = 0;
            it.deadline_time = 16'(d);
        end
        return it;
    endfunction

    function automatic sched_item_t random_item(input logic [1:0] f);
        sched_item_t it;
        it.func          = f;
        it.task_id       = 8'($urandom_range(255));
        it.arrival_time  = 16'($urandom_range(65535));
        it.burst_length  = 16'($urandom_range(65535));
        it.deadline_time = 16'($urandom_range(65535));
        return it;
    endfunction

    // One task set: clear (usually), a batch of loads, then a run of ticks with
    // some noise mixed in. Large batches can overflow the table.
    task automatic run_task_set();
        int n_load;
        int n_tick;
        int k;
        if ($urandom_range(4) != 0)
            push_item(random_item(FUNC_CLEAR));
        n_load = ($urandom_range(7) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
        for (k = 0; k < n_load; k++)
            push_item(random_load());
        n_tick = $urandom_range(4, 30);
        for (k = 0; k < n_tick; k++)
        begin
            if ($urandom_range(99) < 8)
                push_item(random_item(2'($urandom_range(2))));
            else
                push_item(random_item(FUNC_TICK));
        end
    endtask

    // Result side: check every accepted result, stall now and then, hold off once
    // for a long stretch, and stay ready throughout a quiet window.
    initial
    begin : result_sink
        int seen;
        int hold_left;
        bit held;
        seen = 0;
        hold_left = 0;
        held = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                tracker.check_result({ran_valid, ran_slot, ran_task, tick_time, first_run,
                                      completed, newly_dropped, work_pending, table_full});
                seen++;
            end
            if (seen == 80 && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (seen >= 200 && seen < 300)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 10);
        end
    end

    initial
    begin : stimulus
        int random_start;
        int set_count;
        tracker = new;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_CLEAR;
        task_id       = '0;
        arrival_time  = '0;
        burst_length  = '0;
        deadline_time = '0;
        cfg_valid     = 1'b0;
        cfg_hard_mode = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Soft mode: equal deadlines go to the lower slot; a never-arriving task
        // and a zero-work task sit in the table.
        set_hard_mode(1'b0);
        send(FUNC_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(FUNC_LOAD, 8'h00, 16'd0, 16'd2, 16'd5);
        send(FUNC_LOAD, 8'hFF, 16'd0, 16'd1, 16'd5);
        send(FUNC_LOAD, 8'h5A, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(FUNC_LOAD, 8'h33, 16'd0, 16'd0, 16'd0);
        repeat (4) send(FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000);

        // Hard mode: drop at load, zero work never dropped, exact fit, ties on
        // deadline broken by arrival then id, drop at a tick.
        set_hard_mode(1'b1);
        send(FUNC_CLEAR, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send(FUNC_LOAD, 8'h01, 16'd10, 16'd5, 16'd12);
        send(FUNC_LOAD, 8'h02, 16'd0, 16'd0, 16'd0);
        send(FUNC_LOAD, 8'h07, 16'd0, 16'd1, 16'd3);
        send(FUNC_LOAD, 8'h03, 16'd0, 16'd1, 16'd3);
        send(FUNC_LOAD, 8'h00, 16'd1, 16'd1, 16'd3);
        send(FUNC_LOAD, 8'h04, 16'd0, 16'd3, 16'd3);
        send(FUNC_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (4) send(FUNC_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Random task sets; revisit the mode every few sets
        random_start = items_sent;
        set_count = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (set_count % 3 == 2)
                set_hard_mode(1'($urandom_range(1)));
            run_task_set();
            set_count++;
        end
        in_valid <= 1'b0;

        // Drain, then give a stray result time to show up
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.expected_results.size() == 0)
            $display("edf_task_scheduler_unit: match");
        else
            $display("edf_task_scheduler_unit: mismatch");
        $finish;
    end

endmodule
